FILE: design/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the perspective projection setup block.
// ----------------------------------------------------------------------------
package pps_pkg;

  // Pipeline depths of the two datapaths; the shorter one is padded at the top.
  localparam int COT_STAGES   = 55;
  localparam int DEPTH_STAGES = 65;
  localparam int ALIGN_DLY    = DEPTH_STAGES - COT_STAGES;

  // Half angle in Q30 radians: fov * pi_q38 / (45 << 19).
  localparam logic [63:0] PI_Q38   = 64'h3243F6A8885A308D >> 22;
  localparam logic [63:0] TH_DIV   = 64'd23592960;
  localparam int          TH_SHIFT = 19;
  localparam logic [15:0] TH_A     = 16'(PI_Q38 / TH_DIV);
  localparam logic [24:0] TH_B     = 25'(PI_Q38 % TH_DIV);
  localparam int          M45_SH   = 28;
  localparam logic [22:0] TH_M45   = 23'(((64'd1 << M45_SH) + 64'd44) / 64'd45);

  localparam logic [15:0] FOV_STRAIGHT = 16'd46080;
  localparam logic [31:0] ONE_Q30      = 32'h4000_0000;

  // Taylor term divisors as reciprocal multiplies, exact for 32-bit dividends.
  localparam int SIN_L [0:8] = '{3, 5, 6, 7, 7, 8, 8, 9, 9};
  localparam int COS_L [0:8] = '{1, 4, 5, 6, 7, 8, 8, 8, 9};
  localparam logic [33:0] SIN_M [0:8] = '{
    34'(((64'd1 << 35) + 64'd5)   / 64'd6),
    34'(((64'd1 << 37) + 64'd19)  / 64'd20),
    34'(((64'd1 << 38) + 64'd41)  / 64'd42),
    34'(((64'd1 << 39) + 64'd71)  / 64'd72),
    34'(((64'd1 << 39) + 64'd109) / 64'd110),
    34'(((64'd1 << 40) + 64'd155) / 64'd156),
    34'(((64'd1 << 40) + 64'd209) / 64'd210),
    34'(((64'd1 << 41) + 64'd271) / 64'd272),
    34'(((64'd1 << 41) + 64'd341) / 64'd342)
  };
  localparam logic [33:0] COS_M [0:8] = '{
    34'(((64'd1 << 33) + 64'd1)   / 64'd2),
    34'(((64'd1 << 36) + 64'd11)  / 64'd12),
    34'(((64'd1 << 37) + 64'd29)  / 64'd30),
    34'(((64'd1 << 38) + 64'd55)  / 64'd56),
    34'(((64'd1 << 39) + 64'd89)  / 64'd90),
    34'(((64'd1 << 40) + 64'd131) / 64'd132),
    34'(((64'd1 << 40) + 64'd181) / 64'd182),
    34'(((64'd1 << 40) + 64'd239) / 64'd240),
    34'(((64'd1 << 41) + 64'd305) / 64'd306)
  };

  typedef struct packed {
    logic        straight;
    logic        zero;
    logic        ovf;
    logic [31:0] quo;
  } cot_res_t;

  typedef struct packed {
    logic [26:0] far;
    logic [31:0] ds;
    logic [31:0] doff;
  } dep_res_t;

endpackage

FILE: design/pps_cot.sv
// ----------------------------------------------------------------------------
// pps_cot
// Pipelined half-angle cotangent: Taylor sine and cosine, then a radix-2 divide.
// ----------------------------------------------------------------------------
module pps_cot (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [15:0]       fov,
  output logic              out_vld,
  output pps_pkg::cot_res_t res
);
  import pps_pkg::*;

  typedef struct packed {
    logic [31:0] ts;
    logic [31:0] tc;
    logic [33:0] s;
    logic [33:0] c;
    logic [31:0] th2;
  } tay_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] quo;
    logic [31:0] sv;
    logic [30:0] cv;
    logic        zero;
    logic        ovf;
  } dv_t;

  logic [COT_STAGES-1:0] vld_r, vld_nxt;
  logic [COT_STAGES-1:0] str_r, str_nxt;
  logic [31:0] pa_r, pa_nxt, pa2_r, pa2_nxt, th_r, th_nxt;
  logic [21:0] pb_r, pb_nxt;
  logic [15:0] qb_r, qb_nxt;
  tay_t tay_r [0:9];
  tay_t tay_nxt [0:9];
  tay_t mid_r [1:9];
  tay_t mid_nxt [1:9];
  dv_t  dv_r [0:32];
  dv_t  dv_nxt [0:32];

  logic [40:0] pb_full;
  logic [44:0] qb_full;
  logic [63:0] th_sq;
  logic [63:0] mul_s, mul_c;
  logic [65:0] dq_s, dq_c;
  logic [30:0] c_cl;
  logic [46:0] dn;
  logic [32:0] dt;

  always_comb begin
    vld_nxt = {vld_r[COT_STAGES-2:0], in_vld};
    str_nxt = {str_r[COT_STAGES-2:0], (fov >= FOV_STRAIGHT)};

    pa_nxt  = 32'(fov) * 32'(TH_A);
    pb_full = 41'(fov) * 41'(TH_B);
    pb_nxt  = pb_full[TH_SHIFT+21:TH_SHIFT];

    qb_full = 45'(pb_r) * 45'(TH_M45);
    qb_nxt  = qb_full[M45_SH+15:M45_SH];
    pa2_nxt = pa_r;

    th_nxt  = pa2_r + 32'(qb_r);

    th_sq          = 64'(th_r) * 64'(th_r);
    tay_nxt[0].ts  = th_r;
    tay_nxt[0].tc  = ONE_Q30;
    tay_nxt[0].s   = {2'b00, th_r};
    tay_nxt[0].c   = {2'b00, ONE_Q30};
    tay_nxt[0].th2 = th_sq[61:30];

    mul_s = '0;
    mul_c = '0;
    dq_s  = '0;
    dq_c  = '0;
    for (int k = 1; k <= 9; k++) begin
      // term products first, then the divide by (2k)(2k+1) / (2k-1)(2k)
      mul_s         = 64'(tay_r[k-1].ts) * 64'(tay_r[k-1].th2);
      mul_c         = 64'(tay_r[k-1].tc) * 64'(tay_r[k-1].th2);
      mid_nxt[k]    = tay_r[k-1];
      mid_nxt[k].ts = mul_s[61:30];
      mid_nxt[k].tc = mul_c[61:30];

      dq_s          = (66'(mid_r[k].ts) * 66'(SIN_M[k-1])) >> (32 + SIN_L[k-1]);
      dq_c          = (66'(mid_r[k].tc) * 66'(COS_M[k-1])) >> (32 + COS_L[k-1]);
      tay_nxt[k]    = mid_r[k];
      tay_nxt[k].ts = dq_s[31:0];
      tay_nxt[k].tc = dq_c[31:0];
      if (k[0]) begin
        tay_nxt[k].s = mid_r[k].s - {2'b00, dq_s[31:0]};
        tay_nxt[k].c = mid_r[k].c - {2'b00, dq_c[31:0]};
      end else begin
        tay_nxt[k].s = mid_r[k].s + {2'b00, dq_s[31:0]};
        tay_nxt[k].c = mid_r[k].c + {2'b00, dq_c[31:0]};
      end
    end

    // clamp cosine to [0, 1.0]
    if (tay_r[9].c[33]) begin
      c_cl = '0;
    end else if (tay_r[9].c[32:0] > {1'b0, ONE_Q30}) begin
      c_cl = ONE_Q30[30:0];
    end else begin
      c_cl = tay_r[9].c[30:0];
    end
    dv_nxt[0].zero = tay_r[9].s[33] || (tay_r[9].s == '0);
    dv_nxt[0].sv   = tay_r[9].s[31:0];
    dv_nxt[0].cv   = c_cl;
    dv_nxt[0].ovf  = ({17'b0, c_cl} >= {tay_r[9].s[31:0], 16'b0});
    dv_nxt[0].rem  = {18'b0, c_cl[30:16]};
    dv_nxt[0].quo  = '0;

    dn = '0;
    dt = '0;
    for (int j = 1; j <= 32; j++) begin
      dn        = {dv_r[j-1].cv, 16'b0};
      dt        = {dv_r[j-1].rem[31:0], dn[32-j]};
      dv_nxt[j] = dv_r[j-1];
      if (dt >= {1'b0, dv_r[j-1].sv}) begin
        dv_nxt[j].rem          = dt - {1'b0, dv_r[j-1].sv};
        dv_nxt[j].quo[32-j]    = 1'b1;
      end else begin
        dv_nxt[j].rem = dt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    str_r <= str_nxt;
    pa_r  <= pa_nxt;
    pb_r  <= pb_nxt;
    pa2_r <= pa2_nxt;
    qb_r  <= qb_nxt;
    th_r  <= th_nxt;
    for (int k = 0; k <= 9; k++) begin
      tay_r[k] <= tay_nxt[k];
    end
    for (int k = 1; k <= 9; k++) begin
      mid_r[k] <= mid_nxt[k];
    end
    for (int j = 0; j <= 32; j++) begin
      dv_r[j] <= dv_nxt[j];
    end
  end

  assign out_vld      = vld_r[COT_STAGES-1];
  assign res.straight = str_r[COT_STAGES-1];
  assign res.zero     = dv_r[32].zero;
  assign res.ovf      = dv_r[32].ovf;
  assign res.quo      = dv_r[32].quo;

endmodule

FILE: design/pps_depth.sv
// ----------------------------------------------------------------------------
// pps_depth
// Far plane from the box corners (pipelined square root) and the depth terms.
// ----------------------------------------------------------------------------
module pps_depth #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic               no_world,
  input  logic signed [25:0] origin_x,
  input  logic signed [25:0] origin_y,
  input  logic signed [25:0] origin_z,
  input  logic signed [25:0] box_min_x,
  input  logic signed [25:0] box_min_y,
  input  logic signed [25:0] box_min_z,
  input  logic signed [25:0] box_max_x,
  input  logic signed [25:0] box_max_y,
  input  logic signed [25:0] box_max_z,
  input  logic [23:0]        near,
  output logic               out_vld,
  output pps_pkg::dep_res_t  res
);
  import pps_pkg::*;

  localparam logic [63:0] FAR_RAW   = 64'd2048 << FRAC_BITS;
  localparam logic [26:0] FAR_FIXED = (FAR_RAW > 64'h7FF_FFFF) ? 27'h7FF_FFFF : FAR_RAW[26:0];

  typedef struct packed {
    logic [26:0] mx;
    logic [26:0] my;
    logic [26:0] mz;
    logic        nw;
  } ax_t;

  typedef struct packed {
    logic [52:0] sx;
    logic [52:0] sy;
    logic [52:0] sz;
    logic        nw;
  } sq_t;

  typedef struct packed {
    logic [53:0] rem;
    logic [26:0] root;
    logic        nw;
  } rt_t;

  typedef struct packed {
    logic [27:0] rem;
    logic [30:0] quo;
    logic [26:0] den;
    logic [26:0] far;
    logic        pos;
    logic        zero;
    logic        ovf;
  } dd_t;

  typedef struct packed {
    logic [26:0] far;
    logic [31:0] ds;
    logic [31:0] mag;
  } ds_t;

  typedef struct packed {
    logic [26:0] far;
    logic [31:0] ds;
    logic [55:0] prd;
  } pr_t;

  logic [DEPTH_STAGES-1:0] vld_r, vld_nxt;
  ax_t ax_r, ax_nxt;
  sq_t sq_r, sq_nxt;
  rt_t rt_r [0:27];
  rt_t rt_nxt [0:27];
  dd_t dd_r [0:31];
  dd_t dd_nxt [0:31];
  ds_t ds_r, ds_nxt;
  pr_t pr_r, pr_nxt;
  dep_res_t out_r, out_nxt;

  logic [54:0] sq_t_val;
  logic [26:0] far_sel;
  logic [27:0] diff;
  logic [42:0] dn;
  logic [27:0] dt;
  logic [31:0] q_ds;
  logic [55:0] m2;
  logic [31:0] m2c;

  function automatic logic [26:0] axis_max(input logic [25:0] o, input logic [25:0] lo,
                                           input logic [25:0] hi);
    logic [26:0] a;
    logic [26:0] b;
    logic [26:0] ma;
    logic [26:0] mb;
    a  = {lo[25], lo} - {o[25], o};
    b  = {hi[25], hi} - {o[25], o};
    ma = a[26] ? (~a + 27'd1) : a;
    mb = b[26] ? (~b + 27'd1) : b;
    return (ma > mb) ? ma : mb;
  endfunction

  always_comb begin
    vld_nxt = {vld_r[DEPTH_STAGES-2:0], in_vld};

    ax_nxt.mx = axis_max(origin_x, box_min_x, box_max_x);
    ax_nxt.my = axis_max(origin_y, box_min_y, box_max_y);
    ax_nxt.mz = axis_max(origin_z, box_min_z, box_max_z);
    ax_nxt.nw = no_world;

    sq_nxt.sx = 53'(54'(ax_r.mx) * 54'(ax_r.mx));
    sq_nxt.sy = 53'(54'(ax_r.my) * 54'(ax_r.my));
    sq_nxt.sz = 53'(54'(ax_r.mz) * 54'(ax_r.mz));
    sq_nxt.nw = ax_r.nw;

    rt_nxt[0].rem  = 54'(sq_r.sx) + 54'(sq_r.sy) + 54'(sq_r.sz);
    rt_nxt[0].root = '0;
    rt_nxt[0].nw   = sq_r.nw;

    // one root bit per stage; rem holds n - root^2
    sq_t_val = '0;
    for (int j = 1; j <= 27; j++) begin
      sq_t_val  = (55'(rt_r[j-1].root) << (28 - j)) + (55'd1 << (2 * (27 - j)));
      rt_nxt[j] = rt_r[j-1];
      if ({1'b0, rt_r[j-1].rem} >= sq_t_val) begin
        rt_nxt[j].rem            = rt_r[j-1].rem - sq_t_val[53:0];
        rt_nxt[j].root[27 - j]   = 1'b1;
      end
    end

    far_sel          = rt_r[27].nw ? FAR_FIXED : rt_r[27].root;
    diff             = {1'b0, far_sel} - {4'b0, near};
    dd_nxt[0].far    = far_sel;
    dd_nxt[0].pos    = !diff[27] && (diff != '0);
    dd_nxt[0].zero   = (diff == '0);
    dd_nxt[0].den    = diff[27] ? 27'(~diff + 28'd1) : diff[26:0];
    dd_nxt[0].ovf    = ({15'b0, far_sel} >= {dd_nxt[0].den, 15'b0});
    dd_nxt[0].rem    = {16'b0, far_sel[26:15]};
    dd_nxt[0].quo    = '0;

    dn = '0;
    dt = '0;
    for (int j = 1; j <= 31; j++) begin
      dn        = {dd_r[j-1].far, 16'b0};
      dt        = {dd_r[j-1].rem[26:0], dn[31-j]};
      dd_nxt[j] = dd_r[j-1];
      if (dt >= {1'b0, dd_r[j-1].den}) begin
        dd_nxt[j].rem        = dt - {1'b0, dd_r[j-1].den};
        dd_nxt[j].quo[31-j]  = 1'b1;
      end else begin
        dd_nxt[j].rem = dt;
      end
    end

    if (dd_r[31].zero) begin
      q_ds = 32'h8000_0000;
    end else if (dd_r[31].ovf) begin
      q_ds = dd_r[31].pos ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (dd_r[31].pos) begin
      q_ds = ~{1'b0, dd_r[31].quo} + 32'd1;
    end else begin
      q_ds = {1'b0, dd_r[31].quo};
    end
    ds_nxt.far = dd_r[31].far;
    ds_nxt.ds  = q_ds;
    ds_nxt.mag = q_ds[31] ? (~q_ds + 32'd1) : q_ds;

    pr_nxt.far = ds_r.far;
    pr_nxt.ds  = ds_r.ds;
    pr_nxt.prd = 56'(near) * 56'(ds_r.mag);

    m2  = pr_r.prd >> FRAC_BITS;
    m2c = (m2 > 56'h8000_0000) ? 32'h8000_0000 : m2[31:0];
    out_nxt.far = pr_r.far;
    out_nxt.ds  = pr_r.ds;
    if (pr_r.ds[31]) begin
      out_nxt.doff = ~m2c + 32'd1;
    end else begin
      out_nxt.doff = m2c[31] ? 32'h7FFF_FFFF : m2c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ax_r <= ax_nxt;
    sq_r <= sq_nxt;
    for (int j = 0; j <= 27; j++) begin
      rt_r[j] <= rt_nxt[j];
    end
    for (int j = 0; j <= 31; j++) begin
      dd_r[j] <= dd_nxt[j];
    end
    ds_r  <= ds_nxt;
    pr_r  <= pr_nxt;
    out_r <= out_nxt;
  end

  assign out_vld = vld_r[DEPTH_STAGES-1];
  assign res     = out_r;

endmodule

FILE: design/perspective_projection_setup_top.sv
// ----------------------------------------------------------------------------
// perspective_projection_setup_top
// Projection matrix setup with a far plane fitted to the visible box.
// ----------------------------------------------------------------------------
// Fully pipelined: a view can be started every cycle (busy is always low) and
// its result appears on the out_ ports, marked by a one-cycle out_valid pulse.
// The latency is set by the far-plane path: a 27-stage square root followed
// by a 31-stage depth divide; the two cotangent pipelines (55 stages) are
// delayed to line up. Results cannot be held off. near_plane is read directly
// by the pipeline, so write it only while no transaction is in flight.
module perspective_projection_setup_top #(
  parameter int POSITION_FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_no_world,
  input  logic signed [25:0] in_origin_x,
  input  logic signed [25:0] in_origin_y,
  input  logic signed [25:0] in_origin_z,
  input  logic signed [25:0] in_box_min_x,
  input  logic signed [25:0] in_box_min_y,
  input  logic signed [25:0] in_box_min_z,
  input  logic signed [25:0] in_box_max_x,
  input  logic signed [25:0] in_box_max_y,
  input  logic signed [25:0] in_box_max_z,
  input  logic [15:0]        in_fov_horizontal,
  input  logic [15:0]        in_fov_vertical,
  output logic               out_valid,
  output logic [30:0]        out_x_scale,
  output logic signed [31:0] out_y_scale,
  output logic signed [31:0] out_depth_scale,
  output logic signed [31:0] out_depth_offset,
  output logic [26:0]        out_far_plane,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pps_pkg::*;

  localparam logic REG_NEAR = 1'b0;

  logic        acc;
  logic [23:0] near_r, near_nxt;

  logic     cx_vld, cy_vld, dep_vld;
  cot_res_t cx_res, cy_res;
  dep_res_t dep_res;

  logic [ALIGN_DLY-1:0] cx_vld_r, cx_vld_nxt;
  cot_res_t cx_d_r [0:ALIGN_DLY-1];
  cot_res_t cy_d_r [0:ALIGN_DLY-1];
  logic     cx_vld_d;
  cot_res_t cx_d, cy_d;

  logic        out_valid_r, out_valid_nxt;
  logic [30:0] xs_r, xs_nxt;
  logic [31:0] ys_r, ys_nxt;
  logic [31:0] ds_r, ds_nxt;
  logic [31:0] doff_r, doff_nxt;
  logic [26:0] far_r, far_nxt;

  assign busy   = 1'b0;
  assign acc    = start && !busy;
  assign pready = 1'b1;

  always_comb begin
    near_nxt = near_r;
    if (psel && penable && pwrite && pready && (paddr[2] == REG_NEAR)) begin
      near_nxt = pwdata[23:0];
    end
  end

  assign prdata = (paddr[2] == REG_NEAR) ? {8'b0, near_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= 24'd1024;
    end else begin
      near_r <= near_nxt;
    end
  end

  pps_cot u_cot_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (acc),
    .fov     (in_fov_horizontal),
    .out_vld (cx_vld),
    .res     (cx_res)
  );

  pps_cot u_cot_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (acc),
    .fov     (in_fov_vertical),
    .out_vld (cy_vld),
    .res     (cy_res)
  );

  pps_depth #(
    .FRAC_BITS (POSITION_FRACTION_BITS)
  ) u_depth (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (acc),
    .no_world  (in_no_world),
    .origin_x  (in_origin_x),
    .origin_y  (in_origin_y),
    .origin_z  (in_origin_z),
    .box_min_x (in_box_min_x),
    .box_min_y (in_box_min_y),
    .box_min_z (in_box_min_z),
    .box_max_x (in_box_max_x),
    .box_max_y (in_box_max_y),
    .box_max_z (in_box_max_z),
    .near      (near_r),
    .out_vld   (dep_vld),
    .res       (dep_res)
  );

  // align cotangent results with the depth path
  always_comb begin
    cx_vld_nxt = {cx_vld_r[ALIGN_DLY-2:0], cx_vld};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_vld_r <= '0;
    end else begin
      cx_vld_r <= cx_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_d_r[0] <= cx_res;
    cy_d_r[0] <= cy_res;
    for (int i = 1; i < ALIGN_DLY; i++) begin
      cx_d_r[i] <= cx_d_r[i-1];
      cy_d_r[i] <= cy_d_r[i-1];
    end
  end

  assign cx_vld_d = cx_vld_r[ALIGN_DLY-1];
  assign cx_d     = cx_d_r[ALIGN_DLY-1];
  assign cy_d     = cy_d_r[ALIGN_DLY-1];

  always_comb begin
    out_valid_nxt = dep_vld;

    if (cx_d.straight) begin
      xs_nxt = '0;
    end else if (cx_d.zero || cx_d.ovf || cx_d.quo[31]) begin
      xs_nxt = 31'h7FFF_FFFF;
    end else begin
      xs_nxt = cx_d.quo[30:0];
    end

    if (cy_d.straight) begin
      ys_nxt = '0;
    end else if (cy_d.zero || cy_d.ovf || (cy_d.quo > 32'h8000_0000)) begin
      ys_nxt = 32'h8000_0000;
    end else begin
      ys_nxt = ~cy_d.quo + 32'd1;
    end

    ds_nxt   = dep_res.ds;
    doff_nxt = dep_res.doff;
    far_nxt  = dep_res.far;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xs_r   <= xs_nxt;
    ys_r   <= ys_nxt;
    ds_r   <= ds_nxt;
    doff_r <= doff_nxt;
    far_r  <= far_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_x_scale      = xs_r;
  assign out_y_scale      = ys_r;
  assign out_depth_scale  = ds_r;
  assign out_depth_offset = doff_r;
  assign out_far_plane    = far_r;

`ifndef SYNTHESIS
  a_cot_align : assert property (@(posedge clk) disable iff (!rst_n)
    cx_vld_d == dep_vld)
    else $error("cotangent and depth pipelines out of step");

  a_cot_pair : assert property (@(posedge clk) disable iff (!rst_n)
    cx_vld == cy_vld)
    else $error("x and y cotangent pipelines out of step");

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, DEPTH_STAGES + 1))
    else $error("result without a matching start transaction");

  a_y_sign : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_y_scale[31] || (out_y_scale == 32'sd0)))
    else $error("y scale positive");
`endif

endmodule
